// ===== rtl/dsa_pkg.sv =====
// shared constants and the cap calculation for the double-ended stack allocator
// no dependencies
`default_nettype none

package dsa_pkg;

	localparam int ADDR_BITS_DEF   = 16;
	localparam int ALIGN_BYTES_DEF = 8;

	localparam int ARENA_W = 17;
	localparam int REQ_W   = 16;
	localparam int CNT_W   = 16;
	// rounded request plus one header always fits here
	localparam int TOTAL_W = REQ_W + 1;

	localparam logic [ARENA_W-1:0] ARENA_RESET = 17'd65536;

	// top cap: clamp the arena to [2*align, 2^addr_bits], round up, step back one header
	function automatic logic [31:0] cap_of(input logic [31:0] arena,
		input int unsigned addr_bits, input int unsigned align);
		logic [31:0] a;
		logic [31:0] space;
		logic [31:0] mask;
		begin
			space = 32'd1 << addr_bits;
			mask  = 32'(align) - 32'd1;
			a     = arena;
			if (a < 32'(2 * align)) begin
				a = 32'(2 * align);
			end
			if (a > space) begin
				a = space;
			end
			a = (a + mask) & ~mask;
			return a - 32'(align);
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dsa_hdr_mem.sv =====
// header store: one block size per aligned slot, one write and one read port
// synchronous read, data valid in the cycle after the read enable; no package use
`default_nettype none

module dsa_hdr_mem #(
	parameter int IDX_W  = 13,
	parameter int DATA_W = 17
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [IDX_W-1:0]  widx,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [IDX_W-1:0]  ridx,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << IDX_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[widx] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[ridx];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/dsa_ctrl.sv =====
// command sequencer: end pointers, caps, allocate check and the pop walk
// uses dsa_pkg; drives the header store in dsa_hdr_mem
`default_nettype none

module dsa_ctrl #(
	parameter int ADDR_BITS   = dsa_pkg::ADDR_BITS_DEF,
	parameter int ALIGN_BYTES = dsa_pkg::ALIGN_BYTES_DEF,
	parameter int ALIGN_LG    = $clog2(ALIGN_BYTES),
	parameter int IDX_W       = ADDR_BITS - ALIGN_LG
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic                          which_end,
	input  wire logic [dsa_pkg::REQ_W-1:0]     request_bytes,
	input  wire logic [dsa_pkg::CNT_W-1:0]     pop_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dsa_pkg::ARENA_W-1:0]   cfg_data,
	output logic                               done,
	output logic      [ADDR_BITS-1:0]          block_address,
	output logic                               status,
	output logic      [ADDR_BITS-1:0]          bottom_pointer,
	output logic      [ADDR_BITS-1:0]          top_pointer,
	output logic                               mem_we,
	output logic      [IDX_W-1:0]              mem_widx,
	output logic      [dsa_pkg::TOTAL_W-1:0]   mem_wdata,
	output logic                               mem_re,
	output logic      [IDX_W-1:0]              mem_ridx,
	input  wire logic [dsa_pkg::TOTAL_W-1:0]   mem_rdata
);

	localparam int TW = dsa_pkg::TOTAL_W;
	localparam int CW = dsa_pkg::CNT_W;
	localparam int EW = ((ADDR_BITS > TW) ? ADDR_BITS : TW) + 1;

	localparam logic [ADDR_BITS-1:0] TOP_CAP_RST = ADDR_BITS'(dsa_pkg::cap_of(
		32'(dsa_pkg::ARENA_RESET), ADDR_BITS, ALIGN_BYTES));

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_ALLOC   = 2'd1;
	localparam logic [1:0] ST_POP_RD  = 2'd2;
	localparam logic [1:0] ST_POP_UPD = 2'd3;

	logic [1:0]                 state_q;
	logic                       done_q;
	logic [ADDR_BITS-1:0]       bottom_q;
	logic [ADDR_BITS-1:0]       top_q;
	logic [ADDR_BITS-1:0]       top_cap_q;
	logic [dsa_pkg::CNT_W-1:0]  cnt_q;

	logic                       cmd_q;
	logic                       end_q;
	logic [dsa_pkg::REQ_W-1:0]  req_q;
	logic [dsa_pkg::CNT_W-1:0]  num_q;
	logic [ADDR_BITS-1:0]       addr_q;
	logic                       status_q;

	logic [TW-1:0]         sum_req;
	logic [TW-1:0]         total;
	logic [EW-1:0]         nb_ext;
	logic [EW-1:0]         nt_ext;
	logic [EW-1:0]         wr_bot_ext;
	logic                  bot_ovf;
	logic                  top_ovf;
	logic                  alloc_ovf;
	logic [ADDR_BITS-1:0]  new_bot;
	logic [ADDR_BITS-1:0]  new_top;
	logic [ADDR_BITS-1:0]  wr_bot;
	logic [ADDR_BITS-1:0]  bot_hdr;
	logic [ADDR_BITS-1:0]  room;
	logic [ADDR_BITS-1:0]  pop_top;
	logic [ADDR_BITS-1:0]  pop_bot;
	logic [ADDR_BITS-1:0]  cap_new;
	logic                  at_cap;
	logic                  pop_more;
	logic                  cfg_wr;

	always_comb begin
		sum_req    = TW'(req_q) + TW'(ALIGN_BYTES - 1);
		total      = {sum_req[TW-1:ALIGN_LG], {ALIGN_LG{1'b0}}} + TW'(ALIGN_BYTES);
		nb_ext     = EW'(bottom_q) + EW'(total);
		nt_ext     = EW'(top_q) - EW'(total);
		wr_bot_ext = nb_ext - EW'(ALIGN_BYTES);
		bot_ovf    = nb_ext > EW'(top_q);
		top_ovf    = (EW'(total) > EW'(top_q)) || (nt_ext < EW'(bottom_q));
		alloc_ovf  = end_q ? top_ovf : bot_ovf;
		new_bot    = nb_ext[ADDR_BITS-1:0];
		new_top    = nt_ext[ADDR_BITS-1:0];
		wr_bot     = wr_bot_ext[ADDR_BITS-1:0];
		bot_hdr    = bottom_q - ADDR_BITS'(ALIGN_BYTES);

		at_cap   = end_q ? (top_q >= top_cap_q) : (bottom_q == '0);
		pop_more = (cnt_q != num_q) && !at_cap;

		// walk steps saturate at the cap of the end being popped
		room    = top_cap_q - top_q;
		pop_top = (EW'(mem_rdata) > EW'(room)) ? top_cap_q
			: ADDR_BITS'(EW'(top_q) + EW'(mem_rdata));
		pop_bot = (EW'(mem_rdata) > EW'(bottom_q)) ? '0
			: ADDR_BITS'(EW'(bottom_q) - EW'(mem_rdata));

		cap_new = ADDR_BITS'(dsa_pkg::cap_of(32'(cfg_data), ADDR_BITS, ALIGN_BYTES));
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign mem_we    = (state_q == ST_ALLOC) && !alloc_ovf;
	assign mem_widx  = end_q ? new_top[ADDR_BITS-1:ALIGN_LG] : wr_bot[ADDR_BITS-1:ALIGN_LG];
	assign mem_wdata = total;
	assign mem_re    = (state_q == ST_POP_RD) && pop_more;
	assign mem_ridx  = end_q ? top_q[ADDR_BITS-1:ALIGN_LG] : bot_hdr[ADDR_BITS-1:ALIGN_LG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			bottom_q  <= '0;
			top_q     <= TOP_CAP_RST;
			top_cap_q <= TOP_CAP_RST;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						top_cap_q <= cap_new;
						top_q     <= cap_new;
						bottom_q  <= '0;
					end
					if (start) begin
						cnt_q   <= '0;
						state_q <= command ? ST_POP_RD : ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					if (!alloc_ovf) begin
						if (end_q) begin
							top_q <= new_top;
						end else begin
							bottom_q <= new_bot;
						end
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_POP_RD: begin
					if (pop_more) begin
						state_q <= ST_POP_UPD;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_POP_UPD: begin
					// a zero size ends the walk
					if (mem_rdata == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (end_q) begin
							top_q <= pop_top;
						end else begin
							bottom_q <= pop_bot;
						end
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_POP_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cmd_q    <= command;
			end_q    <= which_end;
			req_q    <= request_bytes;
			num_q    <= pop_count;
			addr_q   <= '0;
			status_q <= 1'b0;
		end else if (state_q == ST_ALLOC) begin
			status_q <= alloc_ovf;
			if (alloc_ovf) begin
				addr_q <= '0;
			end else if (end_q) begin
				addr_q <= new_top + ADDR_BITS'(ALIGN_BYTES);
			end else begin
				addr_q <= bottom_q;
			end
		end
	end

	assign done           = done_q;
	assign block_address  = addr_q;
	assign status         = status_q;
	assign bottom_pointer = bottom_q;
	assign top_pointer    = top_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_ovf_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q) |-> (addr_q == '0))
		else $error("refused allocation returned an address");

	a_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		bottom_q <= top_q)
		else $error("stack ends crossed");

	a_top_cap: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= top_cap_q)
		else $error("top end beyond its cap");

	a_pop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q && busy) |-> !mem_we)
		else $error("header written during pop");

	a_alloc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |=> done_q)
		else $error("allocate did not finish in one step");

endmodule

`default_nettype wire

// ===== rtl/double_ended_stack_allocator.sv =====
// An allocate goes from start through the ALLOC state to the done strobe. A pop
// walks the released blocks: every released block costs one header read from
// the header store (state POP_RD) and one update of the end pointer (POP_UPD).
// busy stays high until done; done is high for exactly one cycle, while
// block_address and status hold the result until the next start and
// bottom_pointer and top_pointer keep showing the live end pointers. A write on
// the cfg channel is taken only while busy is low and puts both ends back at
// their caps. The header store is not cleared after reset.
//
// top level: ties the command sequencer to the header store; uses dsa_pkg
`default_nettype none

module double_ended_stack_allocator #(
	parameter int ADDR_BITS   = dsa_pkg::ADDR_BITS_DEF,
	parameter int ALIGN_BYTES = dsa_pkg::ALIGN_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic                          which_end,
	input  wire logic [dsa_pkg::REQ_W-1:0]     request_bytes,
	input  wire logic [dsa_pkg::CNT_W-1:0]     pop_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dsa_pkg::ARENA_W-1:0]   cfg_data,
	output logic                               done,
	output logic      [ADDR_BITS-1:0]          block_address,
	output logic                               status,
	output logic      [ADDR_BITS-1:0]          bottom_pointer,
	output logic      [ADDR_BITS-1:0]          top_pointer
);

	localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
	localparam int IDX_W    = ADDR_BITS - ALIGN_LG;

	logic                          mem_we;
	logic [IDX_W-1:0]              mem_widx;
	logic [dsa_pkg::TOTAL_W-1:0]   mem_wdata;
	logic                          mem_re;
	logic [IDX_W-1:0]              mem_ridx;
	logic [dsa_pkg::TOTAL_W-1:0]   mem_rdata;

	dsa_ctrl #(
		.ADDR_BITS   (ADDR_BITS),
		.ALIGN_BYTES (ALIGN_BYTES),
		.ALIGN_LG    (ALIGN_LG),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.which_end      (which_end),
		.request_bytes  (request_bytes),
		.pop_count      (pop_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.block_address  (block_address),
		.status         (status),
		.bottom_pointer (bottom_pointer),
		.top_pointer    (top_pointer),
		.mem_we         (mem_we),
		.mem_widx       (mem_widx),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_ridx       (mem_ridx),
		.mem_rdata      (mem_rdata)
	);

	dsa_hdr_mem #(
		.IDX_W  (IDX_W),
		.DATA_W (dsa_pkg::TOTAL_W)
	) u_hdr_mem (
		.clk   (clk),
		.we    (mem_we),
		.widx  (mem_widx),
		.wdata (mem_wdata),
		.re    (mem_re),
		.ridx  (mem_ridx),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
